/* design/ndc_pkg.sv */
package ndc_pkg;

  // Widths of the payload and register fields
  localparam int unsigned PH_W       = 11;
  localparam int unsigned EC_W       = 14;
  localparam int unsigned BAND_W     = 10;
  localparam int unsigned CFG_TIME_W = 32;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned EVENT_W    = 4;
  localparam int unsigned PUMP_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Default width of the millisecond counters
  localparam int unsigned TIME_BITS_DEF = 32;

  // Reset values of the registers
  localparam logic [PH_W-1:0]       TARGET_PH_RST   = 11'd600;
  localparam logic [EC_W-1:0]       TARGET_EC_RST   = 14'd150;
  localparam logic [BAND_W-1:0]     BAND_RST        = 10'd20;
  localparam logic [PH_W-1:0]       PH_LOW_LIM_RST  = 11'd300;
  localparam logic [PH_W-1:0]       PH_HIGH_LIM_RST = 11'd900;
  localparam logic [EC_W-1:0]       EC_LOW_LIM_RST  = 14'd10;
  localparam logic [CFG_TIME_W-1:0] TIMEOUT_RST     = 32'd5000;
  localparam logic [CFG_TIME_W-1:0] COOLDOWN_RST    = 32'd300000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_PH   = 3'd0,
    REG_TARGET_EC   = 3'd1,
    REG_BAND        = 3'd2,
    REG_PH_LOW_LIM  = 3'd3,
    REG_PH_HIGH_LIM = 3'd4,
    REG_EC_LOW_LIM  = 3'd5,
    REG_TIMEOUT     = 3'd6,
    REG_COOLDOWN    = 3'd7
  } reg_idx_e;

  // Item kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_ESTOP  = 2'd2
  } func_e;

  // Pump numbers
  typedef enum logic [PUMP_W-1:0] {
    PUMP_PH_DOWN  = 2'd0,
    PUMP_PH_UP    = 2'd1,
    PUMP_NUTRIENT = 2'd2
  } pump_e;

  // Event codes
  typedef enum logic [EVENT_W-1:0] {
    EV_TICK     = 4'd0,
    EV_RUNNING  = 4'd1,
    EV_TIMEOUT  = 4'd2,
    EV_COOLDOWN = 4'd3,
    EV_UNSAFE   = 4'd4,
    EV_PH_DOWN  = 4'd5,
    EV_PH_UP    = 4'd6,
    EV_NUTRIENT = 4'd7,
    EV_ESTOP    = 4'd8,
    EV_IN_BAND  = 4'd9
  } event_e;

  // Input word
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PH_W-1:0]   ph_sample;
    logic [EC_W-1:0]   ec_sample;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [MASK_W-1:0]  pump_mask;
    logic               dosing_active;
    logic [EVENT_W-1:0] event_code;
  } out_word_t;

  // Register file contents
  typedef struct packed {
    logic [PH_W-1:0]       target_ph;
    logic [EC_W-1:0]       target_ec;
    logic [BAND_W-1:0]     band;
    logic [PH_W-1:0]       ph_low_lim;
    logic [PH_W-1:0]       ph_high_lim;
    logic [EC_W-1:0]       ec_low_lim;
    logic [CFG_TIME_W-1:0] dose_timeout_ms;
    logic [CFG_TIME_W-1:0] cooldown_ms;
  } cfg_t;

endpackage

/* design/nutrient_dosing_controller_core.sv */
// Channel   Direction  Handshake              Word
// in        in         in_valid_i/in_ready_o  in_word_i  (func, ph_sample, ec_sample)
// out       out        out_valid_o/out_ready_i out_word_o (pump_mask, dosing_active, event_code)
// cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled; a taken word passes
// the input register, then the result register. The path between them holds the
// timer, limit and dead band compares and a counter increment. Reset loads the
// register defaults, stops the pumps and marks the cooldown as elapsed. A stall on
// the output holds the result register, the next word waits in the input register,
// and in_ready_o drops only while both are full. Configuration is always ready.
module nutrient_dosing_controller_core #(
  parameter int unsigned TIME_BITS = ndc_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ndc_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ndc_pkg::out_word_t             out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ndc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ndc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ndc_pkg::cfg_t      cfg;
  ndc_pkg::in_word_t  in_word_q;
  ndc_pkg::out_word_t out_word_q, res;
  logic               in_valid_q, out_valid_q, advance;

  assign cfg_ready_o = 1'b1;

  ndc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Word moves from input register to result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  ndc_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .word_i (in_word_q),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // A running pump shows exactly one mask bit, an idle block none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($onehot0(out_word_o.pump_mask) &&
                     ((out_word_o.pump_mask != '0) == out_word_o.dosing_active)))
    else $error("pump mask disagrees with dosing flag");

  // An emergency stop always leaves every pump off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.event_code == ndc_pkg::EV_ESTOP)) |->
      !out_word_o.dosing_active)
    else $error("pump still running after emergency stop");

  // Input back-pressure only while the result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

endmodule

/* design/ndc_cfg_regs.sv */
module ndc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [ndc_pkg::CFG_IDX_W-1:0]       wr_index_i,
  input  logic [ndc_pkg::CFG_DATA_W-1:0]      wr_data_i,
  output ndc_pkg::cfg_t                       cfg_o
);

  ndc_pkg::cfg_t cfg_q;

  // Register file, written one register per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_ph       <= ndc_pkg::TARGET_PH_RST;
      cfg_q.target_ec       <= ndc_pkg::TARGET_EC_RST;
      cfg_q.band            <= ndc_pkg::BAND_RST;
      cfg_q.ph_low_lim      <= ndc_pkg::PH_LOW_LIM_RST;
      cfg_q.ph_high_lim     <= ndc_pkg::PH_HIGH_LIM_RST;
      cfg_q.ec_low_lim      <= ndc_pkg::EC_LOW_LIM_RST;
      cfg_q.dose_timeout_ms <= ndc_pkg::TIMEOUT_RST;
      cfg_q.cooldown_ms     <= ndc_pkg::COOLDOWN_RST;
    end else if (wr_en_i) begin
      unique case (ndc_pkg::reg_idx_e'(wr_index_i))
        ndc_pkg::REG_TARGET_PH:   cfg_q.target_ph   <= wr_data_i[ndc_pkg::PH_W-1:0];
        ndc_pkg::REG_TARGET_EC:   cfg_q.target_ec   <= wr_data_i[ndc_pkg::EC_W-1:0];
        ndc_pkg::REG_BAND:        cfg_q.band        <= wr_data_i[ndc_pkg::BAND_W-1:0];
        ndc_pkg::REG_PH_LOW_LIM:  cfg_q.ph_low_lim  <= wr_data_i[ndc_pkg::PH_W-1:0];
        ndc_pkg::REG_PH_HIGH_LIM: cfg_q.ph_high_lim <= wr_data_i[ndc_pkg::PH_W-1:0];
        ndc_pkg::REG_EC_LOW_LIM:  cfg_q.ec_low_lim  <= wr_data_i[ndc_pkg::EC_W-1:0];
        ndc_pkg::REG_TIMEOUT:
          cfg_q.dose_timeout_ms <= wr_data_i[ndc_pkg::CFG_TIME_W-1:0];
        ndc_pkg::REG_COOLDOWN:
          cfg_q.cooldown_ms <= wr_data_i[ndc_pkg::CFG_TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/ndc_ctrl.sv */
module ndc_ctrl #(
  parameter int unsigned TIME_BITS = ndc_pkg::TIME_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ndc_pkg::cfg_t      cfg_i,
  input  logic               step_i,
  input  ndc_pkg::in_word_t  word_i,
  output ndc_pkg::out_word_t res_o
);

  // Compare width covers both the counters and the 32-bit registers
  localparam int unsigned CmpW =
    (TIME_BITS > ndc_pkg::CFG_TIME_W) ? TIME_BITS : ndc_pkg::CFG_TIME_W;
  localparam int unsigned PhSumW = ndc_pkg::PH_W + 1;
  localparam int unsigned EcSumW = ndc_pkg::EC_W + 1;

  logic                       dosing_q, dosing_d;
  logic [ndc_pkg::PUMP_W-1:0] pump_q, pump_d;
  logic [TIME_BITS-1:0]       run_q, run_d;
  logic [TIME_BITS-1:0]       since_q, since_d;
  ndc_pkg::event_e            ev;

  logic              run_sat, since_sat, timed_out, cooling, unsafe;
  logic              want_down, want_up, want_nutr;
  logic [PhSumW-1:0] ph_ext, tp_plus_b, ph_plus_b, tp_ext;
  logic [EcSumW-1:0] ec_plus_b, te_ext;

  // Timer and threshold compares
  always_comb begin
    run_sat   = &run_q;
    since_sat = &since_q;
    timed_out = run_sat || (CmpW'(run_q) > CmpW'(cfg_i.dose_timeout_ms));
    cooling   = !since_sat && (CmpW'(since_q) < CmpW'(cfg_i.cooldown_ms));
    unsafe    = (word_i.ph_sample < cfg_i.ph_low_lim) ||
                (word_i.ph_sample > cfg_i.ph_high_lim) ||
                (word_i.ec_sample < cfg_i.ec_low_lim);
    // Dead band compares rearranged so no side goes negative
    ph_ext    = PhSumW'(word_i.ph_sample);
    tp_ext    = PhSumW'(cfg_i.target_ph);
    tp_plus_b = tp_ext + PhSumW'(cfg_i.band);
    ph_plus_b = ph_ext + PhSumW'(cfg_i.band);
    te_ext    = EcSumW'(cfg_i.target_ec);
    ec_plus_b = EcSumW'(word_i.ec_sample) + EcSumW'(cfg_i.band);
    want_down = ph_ext > tp_plus_b;
    want_up   = ph_plus_b < tp_ext;
    want_nutr = ec_plus_b < te_ext;
  end

  // Next state and event for the current word
  always_comb begin
    dosing_d = dosing_q;
    pump_d   = pump_q;
    run_d    = run_q;
    since_d  = since_q;
    ev       = ndc_pkg::EV_TICK;
    case (ndc_pkg::func_e'(word_i.func))
      ndc_pkg::FUNC_TICK: begin
        run_d   = run_sat ? run_q : run_q + TIME_BITS'(1);
        since_d = since_sat ? since_q : since_q + TIME_BITS'(1);
      end
      ndc_pkg::FUNC_SAMPLE: begin
        if (dosing_q) begin
          if (timed_out) begin
            dosing_d = 1'b0;
            since_d  = '0;
            ev       = ndc_pkg::EV_TIMEOUT;
          end else begin
            ev = ndc_pkg::EV_RUNNING;
          end
        end else if (cooling) begin
          ev = ndc_pkg::EV_COOLDOWN;
        end else if (unsafe) begin
          ev = ndc_pkg::EV_UNSAFE;
        end else if (want_down) begin
          dosing_d = 1'b1;
          pump_d   = ndc_pkg::PUMP_PH_DOWN;
          run_d    = '0;
          ev       = ndc_pkg::EV_PH_DOWN;
        end else if (want_up) begin
          dosing_d = 1'b1;
          pump_d   = ndc_pkg::PUMP_PH_UP;
          run_d    = '0;
          ev       = ndc_pkg::EV_PH_UP;
        end else if (want_nutr) begin
          dosing_d = 1'b1;
          pump_d   = ndc_pkg::PUMP_NUTRIENT;
          run_d    = '0;
          ev       = ndc_pkg::EV_NUTRIENT;
        end else begin
          ev = ndc_pkg::EV_IN_BAND;
        end
      end
      ndc_pkg::FUNC_ESTOP: begin
        dosing_d = 1'b0;
        ev       = ndc_pkg::EV_ESTOP;
      end
      default: ;  // unused selector: nothing changes
    endcase
  end

  // Result reflects the state after the word
  always_comb begin
    res_o.pump_mask     = dosing_d ? (ndc_pkg::MASK_W'(1) << pump_d) : '0;
    res_o.dosing_active = dosing_d;
    res_o.event_code    = ev;
  end

  // Controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dosing_q <= 1'b0;
      pump_q   <= ndc_pkg::PUMP_PH_DOWN;
      run_q    <= '0;
      since_q  <= '1;
    end else if (step_i) begin
      dosing_q <= dosing_d;
      pump_q   <= pump_d;
      run_q    <= run_d;
      since_q  <= since_d;
    end
  end

endmodule
